[sv/hbbb_pkg.sv]
`timescale 1ns / 1ps

package hbbb_pkg;

	// Slots reachable through the fixed-width bank and channel fields
	localparam int BANK_SLOTS = 4;
	localparam int CHAN_SLOTS = 8;

	typedef enum logic [1:0] {
		MODE_OFF  = 2'd0,
		MODE_PRE  = 2'd1,
		MODE_FULL = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		REQ_SAMPLE  = 3'd0,
		REQ_PREHEAT = 3'd1,
		REQ_FULLTOG = 3'd2,
		REQ_BUTTON  = 3'd3,
		REQ_TICK    = 3'd4
	} req_code_t;

	typedef enum logic {
		CFG_PREHEAT  = 1'b0,
		CFG_FULLHEAT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [2:0]         req_type;
		logic [1:0]         bank_select;
		logic [2:0]         sensor_channel;
		logic signed [15:0] sample_temp;
	} item_t;

	typedef struct packed {
		logic               valid;
		logic               index;
		logic signed [15:0] data;
	} cfg_wr_t;

	typedef struct packed {
		logic       heater_drive;
		logic [1:0] drive_bank;
		logic [1:0] active_mode;
		logic [7:0] all_modes;
	} status_t;

endpackage

[sv/hbbb_in_reg.sv]
`timescale 1ns / 1ps

module hbbb_in_reg
	import hbbb_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	input  item_t in_item,
	input  logic  advance,
	output logic  item_valid_s1,
	output item_t item_s1
);

	// Hold the request while the core cannot take it
	assign in_stall = item_valid_s1 & ~advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			item_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

[sv/hbbb_core.sv]
`timescale 1ns / 1ps

module hbbb_core
	import hbbb_pkg::*;
#(
	parameter int BANK_COUNT   = 4,
	parameter int SENSOR_COUNT = 8
) (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_wr_t cfg_wr,
	input  logic    item_valid_s1,
	input  item_t   item_s1,
	output logic    advance,
	output logic    out_valid,
	input  logic    out_stall,
	output status_t status_s2
);

	logic signed [15:0] pre_thr_q;
	logic signed [15:0] full_thr_q;
	mode_t              mode_q [BANK_SLOTS];
	mode_t              mode_d [BANK_SLOTS];
	logic signed [15:0] temp_q [CHAN_SLOTS];
	logic [1:0]         sel_q;
	logic [1:0]         sel_d;
	logic               drv_q;
	logic               drv_d;
	logic               out_valid_q;
	logic               fire;
	logic [BANK_SLOTS-1:0] bank_en;
	mode_t              cur_mode;
	logic signed [15:0] t0;
	logic signed [15:0] t1;
	status_t            status_d;

	assign advance   = ~out_valid_q | ~out_stall;
	assign fire      = item_valid_s1 & advance;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_thr_q  <= '0;
			full_thr_q <= '0;
		end else if (cfg_wr.valid) begin
			case (cfg_wr.index)
				CFG_PREHEAT:  pre_thr_q  <= cfg_wr.data;
				CFG_FULLHEAT: full_thr_q <= cfg_wr.data;
				default: ;
			endcase
		end
	end

	// Only slots that exist get storage; the rest read as off / zero
	for (genvar i = 0; i < BANK_SLOTS; i++) begin : g_bank
		assign bank_en[i] = (i < BANK_COUNT);
		if (i < BANK_COUNT) begin : g_reg
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					mode_q[i] <= MODE_OFF;
				end else begin
					mode_q[i] <= mode_d[i];
				end
			end
		end else begin : g_none
			assign mode_q[i] = MODE_OFF;
		end
	end

	for (genvar c = 0; c < CHAN_SLOTS; c++) begin : g_chan
		if (c < SENSOR_COUNT) begin : g_reg
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					temp_q[c] <= '0;
				end else if (fire && item_s1.req_type == REQ_SAMPLE
						&& item_s1.sensor_channel == 3'(c)) begin
					temp_q[c] <= item_s1.sample_temp;
				end
			end
		end else begin : g_none
			assign temp_q[c] = '0;
		end
	end

	assign cur_mode = mode_q[sel_q];
	assign t0       = temp_q[{sel_q, 1'b0}];
	assign t1       = temp_q[{sel_q, 1'b1}];

	always_comb begin
		mode_d = mode_q;
		sel_d  = sel_q;
		drv_d  = drv_q;
		if (fire) begin
			case (item_s1.req_type)
				REQ_PREHEAT: begin
					if (bank_en[item_s1.bank_select]) begin
						if (item_s1.bank_select != sel_q) begin
							drv_d = 1'b0;
						end
						sel_d = item_s1.bank_select;
						mode_d[item_s1.bank_select] = MODE_PRE;
					end
				end
				REQ_FULLTOG: begin
					if (bank_en[item_s1.bank_select]) begin
						if (item_s1.bank_select != sel_q) begin
							drv_d = 1'b0;
						end
						sel_d = item_s1.bank_select;
						mode_d[item_s1.bank_select] =
							(mode_q[item_s1.bank_select] == MODE_FULL) ? MODE_OFF : MODE_FULL;
					end
				end
				REQ_BUTTON: begin
					case (cur_mode)
						MODE_OFF: mode_d[sel_q] = MODE_PRE;
						MODE_PRE: mode_d[sel_q] = MODE_FULL;
						default:  mode_d[sel_q] = MODE_OFF;
					endcase
				end
				REQ_TICK: begin
					case (cur_mode)
						MODE_PRE: drv_d = (t0 < pre_thr_q) && (t1 < pre_thr_q);
						MODE_FULL: begin
							if ((t0 < full_thr_q) || (t1 < full_thr_q)) begin
								drv_d = 1'b1;
							end else begin
								drv_d = 1'b0;
								mode_d[sel_q] = MODE_OFF;
							end
						end
						default: drv_d = 1'b0;
					endcase
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		status_d.heater_drive = drv_d;
		status_d.drive_bank   = sel_d;
		status_d.active_mode  = mode_d[sel_d];
		for (int i = 0; i < BANK_SLOTS; i++) begin
			status_d.all_modes[2*i +: 2] = mode_d[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q       <= '0;
			drv_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			sel_q <= sel_d;
			drv_q <= drv_d;
			if (advance) begin
				out_valid_q <= item_valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_s2 <= status_d;
		end
	end

endmodule

[sv/heater_bank_bang_bang_controller_unit.sv]
`timescale 1ns / 1ps
// A request taken into the input register passes into the output status register when that
// register is free, unless a stalled status holds it back.
// Throughput: one request per cycle; only a stalled output register holds back input.
// Reset (arst_n low, asynchronous): all banks off, bank 0 active, drive off,
// thermistor readings and both thresholds zero, no request or status pending.

module heater_bank_bang_bang_controller_unit
	import hbbb_pkg::*;
#(
	parameter int BANK_COUNT   = 4,
	parameter int SENSOR_COUNT = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic signed [15:0] cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         req_type,
	input  logic [1:0]         bank_select,
	input  logic [2:0]         sensor_channel,
	input  logic signed [15:0] sample_temp,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               heater_drive,
	output logic [1:0]         drive_bank,
	output logic [1:0]         active_mode,
	output logic [7:0]         all_modes
);

	item_t   in_item;
	item_t   item_s1;
	logic    item_valid_s1;
	logic    advance;
	cfg_wr_t cfg_wr;
	status_t status_s2;

	assign cfg_ready = 1'b1;

	assign cfg_wr.valid = cfg_valid & cfg_ready;
	assign cfg_wr.index = cfg_index;
	assign cfg_wr.data  = cfg_data;

	assign in_item.req_type       = req_type;
	assign in_item.bank_select    = bank_select;
	assign in_item.sensor_channel = sensor_channel;
	assign in_item.sample_temp    = sample_temp;

	hbbb_in_reg u_in_reg (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_item       (in_item),
		.advance       (advance),
		.item_valid_s1 (item_valid_s1),
		.item_s1       (item_s1)
	);

	hbbb_core #(
		.BANK_COUNT   (BANK_COUNT),
		.SENSOR_COUNT (SENSOR_COUNT)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr        (cfg_wr),
		.item_valid_s1 (item_valid_s1),
		.item_s1       (item_s1),
		.advance       (advance),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status_s2     (status_s2)
	);

	assign heater_drive = status_s2.heater_drive;
	assign drive_bank   = status_s2.drive_bank;
	assign active_mode  = status_s2.active_mode;
	assign all_modes    = status_s2.all_modes;

endmodule

[sim/heater_bank_status_checker.sv]
`timescale 1ns / 1ps

module heater_bank_status_checker
	import hbbb_pkg::*;
#(
	parameter int BANK_COUNT   = 4,
	parameter int SENSOR_COUNT = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic               cfg_index,
	input  logic signed [15:0] cfg_data,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [2:0]         req_type,
	input  logic [1:0]         bank_select,
	input  logic [2:0]         sensor_channel,
	input  logic signed [15:0] sample_temp,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic               heater_drive,
	input  logic [1:0]         drive_bank,
	input  logic [1:0]         active_mode,
	input  logic [7:0]         all_modes,
	output int                 mismatch_count,
	output int                 status_pending,
	output int                 status_checked
);

	mode_t              bank_mode [BANK_COUNT];
	logic [1:0]         active_bank;
	logic signed [15:0] therm [SENSOR_COUNT];
	logic               drive_on;
	logic signed [15:0] preheat_limit;
	logic signed [15:0] fullheat_limit;
	status_t            status_q [$];
	int                 n_bad;
	int                 n_seen;

	function automatic logic signed [15:0] therm_reading(int ch);
		if (ch < SENSOR_COUNT) begin
			return therm[ch];
		end
		return 16'sd0;
	endfunction

	// a switch to another bank starts it with the heater off
	function automatic void switch_bank(int b);
		if (b != int'(active_bank)) begin
			drive_on = 1'b0;
		end
		active_bank = 2'(b);
	endfunction

	function automatic status_t apply_request(item_t r);
		status_t            s;
		int                 b;
		int                 ab;
		logic signed [15:0] t0;
		logic signed [15:0] t1;
		b = int'(r.bank_select);
		case (r.req_type)
			REQ_SAMPLE: begin
				if (int'(r.sensor_channel) < SENSOR_COUNT) begin
					therm[r.sensor_channel] = r.sample_temp;
				end
			end
			REQ_PREHEAT: begin
				if (b < BANK_COUNT) begin
					switch_bank(b);
					bank_mode[b] = MODE_PRE;
				end
			end
			REQ_FULLTOG: begin
				if (b < BANK_COUNT) begin
					switch_bank(b);
					if (bank_mode[b] == MODE_FULL) begin
						bank_mode[b] = MODE_OFF;
					end else begin
						bank_mode[b] = MODE_FULL;
					end
				end
			end
			REQ_BUTTON: begin
				ab = int'(active_bank);
				if (ab < BANK_COUNT) begin
					case (bank_mode[ab])
						MODE_OFF: bank_mode[ab] = MODE_PRE;
						MODE_PRE: bank_mode[ab] = MODE_FULL;
						default:  bank_mode[ab] = MODE_OFF;
					endcase
				end
			end
			REQ_TICK: begin
				ab = int'(active_bank);
				if (ab >= BANK_COUNT) begin
					drive_on = 1'b0;
				end else begin
					t0 = therm_reading(2 * ab);
					t1 = therm_reading(2 * ab + 1);
					if (bank_mode[ab] == MODE_PRE) begin
						drive_on = (t0 < preheat_limit) && (t1 < preheat_limit);
					end else if (bank_mode[ab] == MODE_FULL) begin
						// both readings at the stop point end the full-heat run
						if ((t0 < fullheat_limit) || (t1 < fullheat_limit)) begin
							drive_on = 1'b1;
						end else begin
							drive_on = 1'b0;
							bank_mode[ab] = MODE_OFF;
						end
					end else begin
						drive_on = 1'b0;
					end
				end
			end
			default: ;
		endcase

		s.heater_drive = drive_on;
		s.drive_bank   = active_bank;
		s.active_mode  = (int'(active_bank) < BANK_COUNT) ? bank_mode[active_bank] : MODE_OFF;
		s.all_modes    = '0;
		for (int i = 0; i < BANK_SLOTS; i++) begin
			if (i < BANK_COUNT) begin
				s.all_modes[2*i +: 2] = bank_mode[i];
			end
		end
		return s;
	endfunction

	task automatic check_field(string name, int want, int got);
		if (want != got) begin
			n_bad++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		status_t want;
		item_t   req;
		if (!arst_n) begin
			for (int i = 0; i < BANK_COUNT; i++) begin
				bank_mode[i] = MODE_OFF;
			end
			for (int i = 0; i < SENSOR_COUNT; i++) begin
				therm[i] = 16'sd0;
			end
			active_bank    = '0;
			drive_on       = 1'b0;
			preheat_limit  = 16'sd0;
			fullheat_limit = 16'sd0;
			status_q.delete();
			n_bad          = 0;
			n_seen         = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_PREHEAT) begin
					preheat_limit = cfg_data;
				end else begin
					fullheat_limit = cfg_data;
				end
			end
			// retire the oldest status before queueing this edge's request
			if (out_valid && !out_stall) begin
				n_seen++;
				if (status_q.size() == 0) begin
					n_bad++;
					$display("%0t: status with no request pending, expected none, actual %0h",
						$time, {heater_drive, drive_bank, active_mode, all_modes});
				end else begin
					want = status_q.pop_front();
					check_field("heater_drive", want.heater_drive, heater_drive);
					check_field("drive_bank", want.drive_bank, drive_bank);
					check_field("active_mode", want.active_mode, active_mode);
					check_field("all_modes", want.all_modes, all_modes);
				end
			end
			if (in_valid && !in_stall) begin
				req.req_type       = req_type;
				req.bank_select    = bank_select;
				req.sensor_channel = sensor_channel;
				req.sample_temp    = sample_temp;
				status_q.push_back(apply_request(req));
			end
		end
		mismatch_count <= n_bad;
		status_pending <= status_q.size();
		status_checked <= n_seen;
	end

endmodule

[sim/heater_bank_bang_bang_controller_unit_tb.sv]
`timescale 1ns / 1ps

module heater_bank_bang_bang_controller_unit_tb;
	import hbbb_pkg::*;

	localparam int          ITEM_TARGET  = 1450;
	localparam int          PHASES       = 6;
	localparam int          CYCLE_LIMIT  = 400000;
	localparam int          DRAIN_CYCLES = 8;
	localparam logic [2:0]  REQ_SPARE_LO = REQ_TICK + 3'd1;
	localparam logic [2:0]  REQ_SPARE_HI = '1;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid;
	logic               cfg_ready;
	logic               cfg_index;
	logic signed [15:0] cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic [2:0]         req_type;
	logic [1:0]         bank_select;
	logic [2:0]         sensor_channel;
	logic signed [15:0] sample_temp;
	logic               out_valid;
	logic               out_stall;
	logic               heater_drive;
	logic [1:0]         drive_bank;
	logic [1:0]         active_mode;
	logic [7:0]         all_modes;

	int                 mismatch_count;
	int                 status_pending;
	int                 status_checked;
	int                 cycle_count = 0;
	int                 requests_sent = 0;
	int                 setting_count = 0;
	bit                 idle_on = 1'b1;
	logic signed [15:0] preheat_set = '0;
	logic signed [15:0] fullheat_set = '0;
	logic [1:0]         focus_bank = '0;

	heater_bank_bang_bang_controller_unit DUT (.*);

	heater_bank_status_checker status_checker (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// status sink: random hold per status, with stretches of none
	initial begin
		int hold;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			hold = idle_on ? $urandom_range(0, 12) : 0;
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	function automatic item_t make_request(logic [2:0] op, int bank, int ch, int temp);
		item_t r;
		r.req_type       = op;
		r.bank_select    = 2'(bank);
		r.sensor_channel = 3'(ch);
		r.sample_temp    = 16'(temp);
		return r;
	endfunction

	function automatic logic signed [15:0] temp_near_limit();
		int v;
		v = $urandom_range(0, 1) ? int'(preheat_set) : int'(fullheat_set);
		v = v + int'($urandom_range(0, 16)) - 8;
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return 16'(v);
	endfunction

	// mostly well-formed traffic around the bank being worked on
	function automatic item_t pick_request();
		item_t r;
		int    roll;
		r.bank_select    = 2'($urandom_range(0, 3));
		r.sensor_channel = 3'($urandom_range(0, 7));
		r.sample_temp    = 16'($urandom);
		roll = $urandom_range(0, 99);
		if (roll < 36) begin
			r.req_type = REQ_SAMPLE;
			if ($urandom_range(0, 3) != 0) r.sensor_channel = {focus_bank, 1'($urandom)};
			if ($urandom_range(0, 2) != 0) r.sample_temp = temp_near_limit();
		end else if (roll < 56) begin
			r.req_type = (roll < 46) ? REQ_PREHEAT : REQ_FULLTOG;
			if ($urandom_range(0, 4) < 3) r.bank_select = focus_bank;
			focus_bank = r.bank_select;
		end else if (roll < 66) begin
			r.req_type = REQ_BUTTON;
		end else if (roll < 94) begin
			r.req_type = REQ_TICK;
		end else begin
			r.req_type = 3'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
		end
		return r;
	endfunction

	task automatic send_request(item_t r);
		int gap;
		gap = idle_on ? $urandom_range(0, 12) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid       <= 1'b1;
		req_type       <= r.req_type;
		bank_select    <= r.bank_select;
		sensor_channel <= r.sensor_channel;
		sample_temp    <= r.sample_temp;
		do @(posedge clk); while (in_stall);
		requests_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (status_pending != 0);
	endtask

	task automatic set_thresholds(logic signed [15:0] pre, logic signed [15:0] full);
		preheat_set  = pre;
		fullheat_set = full;
		cfg_valid   <= 1'b1;
		cfg_index   <= CFG_PREHEAT;
		cfg_data    <= pre;
		do @(posedge clk); while (!cfg_ready);
		cfg_index   <= CFG_FULLHEAT;
		cfg_data    <= full;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid   <= 1'b0;
		setting_count++;
	endtask

	initial begin
		item_t r;
		int    counted;
		cfg_valid      = 1'b0;
		cfg_index      = CFG_PREHEAT;
		cfg_data       = '0;
		in_valid       = 1'b0;
		req_type       = REQ_SAMPLE;
		bank_select    = '0;
		sensor_channel = '0;
		sample_temp    = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_thresholds(16'sd100, 16'sd200);
		send_request(make_request(REQ_SAMPLE, 0, 0, 32767));
		send_request(make_request(REQ_SAMPLE, 3, 1, -32768));
		// reselect the bank that is already active
		send_request(make_request(REQ_PREHEAT, 0, 5, 0));
		send_request(make_request(REQ_TICK, 1, 2, 0));
		send_request(make_request(REQ_SAMPLE, 0, 0, 99));
		send_request(make_request(REQ_TICK, 0, 0, 0));
		send_request(make_request(REQ_PREHEAT, 0, 7, -1));
		send_request(make_request(REQ_FULLTOG, 0, 0, 0));
		send_request(make_request(REQ_TICK, 3, 7, -1));
		send_request(make_request(REQ_SAMPLE, 0, 0, 200));
		send_request(make_request(REQ_SAMPLE, 0, 1, 32767));
		// both readings at the stop point: full-heat drops to off
		send_request(make_request(REQ_TICK, 0, 0, 0));
		send_request(make_request(REQ_BUTTON, 2, 3, 0));
		send_request(make_request(REQ_BUTTON, 1, 4, 0));
		send_request(make_request(REQ_TICK, 0, 0, 0));
		send_request(make_request(REQ_BUTTON, 0, 0, 0));
		send_request(make_request(REQ_BUTTON, 0, 0, 0));
		send_request(make_request(REQ_BUTTON, 0, 0, 0));
		send_request(make_request(REQ_FULLTOG, 3, 0, 0));
		send_request(make_request(REQ_SAMPLE, 0, 6, -32768));
		send_request(make_request(REQ_TICK, 0, 0, 0));
		// switch away from a bank with the heater on
		send_request(make_request(REQ_PREHEAT, 2, 0, 0));
		send_request(make_request(REQ_FULLTOG, 3, 0, 0));
		send_request(make_request(REQ_SPARE_LO, 3, 7, 32767));
		send_request(make_request(REQ_SPARE_HI, 3, 7, -32768));

		for (int ph = 0; ph < PHASES; ph++) begin
			wait_drained();
			repeat ($urandom_range(0, 4)) @(posedge clk);
			case (ph)
				0:       set_thresholds(16'($urandom_range(0, 640)), 16'($urandom_range(0, 960)));
				1:       set_thresholds(-16'sd32768, 16'sd32767);
				2:       set_thresholds(16'sd32767, -16'sd32768);
				3:       set_thresholds(16'sd32767, 16'sd32767);
				4:       set_thresholds(-16'sd32768, -16'sd32768);
				default: set_thresholds(16'($urandom), 16'($urandom));
			endcase
			counted = 0;
			while (counted < ITEM_TARGET / PHASES) begin
				if ($urandom_range(0, 49) == 0) idle_on = !idle_on;
				// hold the sender midway through each phase until every status is back
				if (counted == ITEM_TARGET / PHASES / 2) begin
					wait_drained();
				end
				r = pick_request();
				send_request(r);
				if (r.req_type <= REQ_TICK) counted++;
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d requests across %0d threshold settings", requests_sent,
			setting_count);
		$display("checked %0d status results, %0d mismatching fields", status_checked,
			mismatch_count);
		if (mismatch_count == 0 && status_pending == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
